/* rtl/spf_pkg.sv */
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types, constants and character helpers of the sensor packet framer.
// ----------------------------------------------------------------------------
package spf_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ENABLE = 2'd0;
    localparam logic [1:0] CFG_PAN    = 2'd1;
    localparam logic [1:0] CFG_UNIT   = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Packet layout: 27 bytes, message field starts at byte 8.
    localparam logic [4:0] PKT_LAST  = 5'd26;
    localparam logic [4:0] MSG_FIRST = 5'd8;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [6:0] WHOLE_MAX = 7'd99;

    localparam logic [7:0] CHAR_CR = 8'h0D;

    // One classified reading, ready to be framed.
    typedef struct packed {
        logic       hum;        // humidity message when set, temperature otherwise
        logic       minus;      // temperature sign is negative
        logic [3:0] whole_tens;
        logic [3:0] whole_ones;
        logic [3:0] frac;
        logic [1:0] seq_hund;
        logic [3:0] seq_tens;
        logic [3:0] seq_ones;
        logic       wrap;       // a status packet follows this one
    } t_job;

    localparam int JOB_W = $bits(t_job);

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
        end else begin
            c = 8'h37 + {4'd0, nib};
        end
        return c;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] dig);
        return 8'h30 + {4'd0, dig};
    endfunction

endpackage

/* rtl/spf_front.sv */
// ----------------------------------------------------------------------------
// spf_front
// Accepts readings, tracks the sequence number and turns each reading into
// decimal digits through a four-stage pipeline feeding the job queue.
// ----------------------------------------------------------------------------
module spf_front
    import spf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_enable,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [15:0] i_temp_centi,
    input  logic [15:0] i_hum_centi,
    input  logic        i_q_full,
    output logic        o_push,
    output t_job        o_push_job
);

    logic        adv;
    logic        acc;

    logic [7:0]  r_seq;
    logic [7:0]  n_seq;

    // Stage A: magnitude plus rounding offset.
    logic        r_a_v;
    logic        r_a_hum;
    logic        r_a_neg;
    logic [16:0] r_a_mag;
    logic [7:0]  r_a_seq;
    logic        r_a_wrap;

    // Stage B: tenths.
    logic        r_b_v;
    logic        r_b_hum;
    logic        r_b_neg;
    logic [12:0] r_b_q10;
    logic [7:0]  r_b_seq;
    logic        r_b_wrap;

    // Stage C: whole part and fraction digit.
    logic        r_c_v;
    logic        r_c_hum;
    logic        r_c_minus;
    logic [9:0]  r_c_whole;
    logic [3:0]  r_c_frac;
    logic [7:0]  r_c_seq;
    logic [4:0]  r_c_sq;
    logic        r_c_wrap;

    // Stage D: finished job.
    logic        r_d_v;
    t_job        r_d_job;

    logic        in_neg;
    logic [16:0] in_mag;
    logic [34:0] b_prod;
    logic [25:0] c_prod;
    logic [9:0]  c_whole;
    logic [15:0] c_sq_prod;
    logic [6:0]  d_wsat;
    logic [14:0] d_wt_prod;
    logic [3:0]  d_wt;
    logic [1:0]  d_hund;
    t_job        n_d_job;

    assign adv        = !(r_d_v && i_q_full);
    assign o_in_stall = !adv;
    assign acc        = i_in_valid && adv;
    assign o_push     = r_d_v && !i_q_full;
    assign o_push_job = r_d_job;

    always_comb begin
        n_seq = r_seq;
        if (acc && i_enable) begin
            n_seq = (r_seq == 8'hFF) ? 8'd1 : r_seq + 8'd1;
        end
    end

    // |t - 5| equals |t| + 5 for negative t, so one magnitude serves both signs.
    always_comb begin
        in_neg = 1'b0;
        in_mag = {1'b0, i_hum_centi} + 17'd5;
        if (!i_action) begin
            in_neg = i_temp_centi[15];
            in_mag = (in_neg ? (17'd0 - {1'b1, i_temp_centi}) : {1'b0, i_temp_centi})
                     + 17'd5;
        end
    end

    // Division by ten through reciprocal multiplies, exact over the ranges used.
    assign b_prod    = 35'(r_a_mag) * 35'd209716;
    assign c_prod    = 26'(r_b_q10) * 26'd6554;
    assign c_whole   = c_prod[25:16];
    assign c_sq_prod = 16'(r_b_seq) * 16'd205;
    assign d_wsat    = (r_c_whole > 10'(WHOLE_MAX)) ? WHOLE_MAX : r_c_whole[6:0];
    assign d_wt_prod = 15'(d_wsat) * 15'd205;
    assign d_wt      = d_wt_prod[14:11];

    always_comb begin
        if (r_c_sq >= 5'd20) begin
            d_hund = 2'd2;
        end else if (r_c_sq >= 5'd10) begin
            d_hund = 2'd1;
        end else begin
            d_hund = 2'd0;
        end
        n_d_job.hum        = r_c_hum;
        n_d_job.minus      = r_c_minus;
        n_d_job.whole_tens = d_wt;
        n_d_job.whole_ones = 4'(d_wsat - 7'(d_wt) * 7'd10);
        n_d_job.frac       = r_c_frac;
        n_d_job.seq_hund   = d_hund;
        n_d_job.seq_tens   = 4'(r_c_sq - 5'(d_hund) * 5'd10);
        n_d_job.seq_ones   = 4'(r_c_seq - 8'(r_c_sq) * 8'd10);
        n_d_job.wrap       = r_c_wrap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= 8'd0;
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else begin
            r_seq <= n_seq;
            if (adv) begin
                r_a_v <= acc && i_enable;
                r_b_v <= r_a_v;
                r_c_v <= r_b_v;
                r_d_v <= r_c_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_hum   <= i_action;
            r_a_neg   <= in_neg;
            r_a_mag   <= in_mag;
            r_a_seq   <= r_seq;
            r_a_wrap  <= (r_seq == 8'hFF);

            r_b_hum   <= r_a_hum;
            r_b_neg   <= r_a_neg;
            r_b_q10   <= b_prod[33:21];
            r_b_seq   <= r_a_seq;
            r_b_wrap  <= r_a_wrap;

            r_c_hum   <= r_b_hum;
            r_c_minus <= r_b_neg && (r_b_q10 != 13'd0);
            r_c_whole <= c_whole;
            r_c_frac  <= 4'(r_b_q10 - 13'(c_whole) * 13'd10);
            r_c_seq   <= r_b_seq;
            r_c_sq    <= c_sq_prod[15:11];
            r_c_wrap  <= r_b_wrap;

            r_d_job   <= n_d_job;
        end
    end

    // After the sequence wraps, the next data packet carries number one.
    a_seq_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_enable && r_seq == 8'hFF) |=> (r_seq == 8'd1))
        else $error("sequence did not skip zero after wrap");

    a_seq_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!(acc && i_enable)) |=> $stable(r_seq))
        else $error("sequence moved without an enabled reading");

endmodule

/* rtl/spf_queue.sv */
// ----------------------------------------------------------------------------
// spf_queue
// Short job queue between the classifying front and the byte emitter.
// ----------------------------------------------------------------------------
module spf_queue
    import spf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_push_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_next(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_next(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("job queue underflow");

endmodule

/* rtl/spf_back.sv */
// ----------------------------------------------------------------------------
// spf_back
// Takes jobs from the queue and emits each packet one byte per beat through
// an output register, with the status packet appended after a wrap.
// ----------------------------------------------------------------------------
module spf_back
    import spf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_pan_code,
    input  logic [7:0]  i_unit_code,
    input  logic        i_q_valid,
    input  t_job        i_q_job,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_data_byte,
    output logic        o_packet_end,
    output logic        o_last_of_run
);

    logic       r_busy;
    logic       r_status;
    logic [4:0] r_idx;
    t_job       r_job;

    logic       r_out_v;
    logic [7:0] r_byte;
    logic       r_end;
    logic       r_last;

    logic       emit;
    logic       take;
    logic       last_byte;
    logic       run_end;
    logic [4:0] msg_pos;
    logic [7:0] msg_byte;
    logic [7:0] pkt_byte;

    assign last_byte = (r_idx == PKT_LAST);
    assign run_end   = last_byte && (r_status || !r_job.wrap);
    assign emit      = r_busy && (!r_out_v || !i_out_stall);
    assign take      = i_q_valid && (!r_busy || (emit && run_end));
    assign o_pop     = take;
    assign msg_pos   = r_idx - MSG_FIRST;

    always_comb begin
        msg_byte = 8'h3F;
        if (r_status) begin
            case (msg_pos)
                5'd0:    msg_byte = "S";
                5'd1:    msg_byte = "S";
                5'd2:    msg_byte = "3";
                5'd3:    msg_byte = "6";
                5'd4:    msg_byte = "1";
                5'd5:    msg_byte = "#";
                5'd6:    msg_byte = "H";
                5'd7:    msg_byte = "1";
                default: msg_byte = "W";
            endcase
        end else if (r_job.hum) begin
            case (msg_pos)
                5'd0:    msg_byte = "H";
                5'd1:    msg_byte = "S";
                5'd2:    msg_byte = "S";
                5'd3:    msg_byte = "A";
                5'd4:    msg_byte = digit_char(r_job.whole_tens);
                5'd5:    msg_byte = digit_char(r_job.whole_ones);
                5'd6:    msg_byte = ".";
                5'd7:    msg_byte = digit_char(r_job.frac);
                default: msg_byte = "-";
            endcase
        end else begin
            case (msg_pos)
                5'd0:    msg_byte = "T";
                5'd1:    msg_byte = "S";
                5'd2:    msg_byte = "S";
                5'd3:    msg_byte = "A";
                5'd4:    msg_byte = r_job.minus ? "-" : "+";
                5'd5:    msg_byte = digit_char(r_job.whole_tens);
                5'd6:    msg_byte = digit_char(r_job.whole_ones);
                5'd7:    msg_byte = ".";
                default: msg_byte = digit_char(r_job.frac);
            endcase
        end
    end

    always_comb begin
        case (r_idx)
            5'd0:    pkt_byte = "m";
            5'd1:    pkt_byte = hex_char(i_pan_code[15:12]);
            5'd2:    pkt_byte = hex_char(i_pan_code[11:8]);
            5'd3:    pkt_byte = hex_char(i_pan_code[7:4]);
            5'd4:    pkt_byte = hex_char(i_pan_code[3:0]);
            5'd5:    pkt_byte = hex_char(i_unit_code[7:4]);
            5'd6:    pkt_byte = hex_char(i_unit_code[3:0]);
            5'd7:    pkt_byte = "d";
            5'd17:   pkt_byte = "r";
            5'd18:   pkt_byte = "-";
            5'd19:   pkt_byte = "0";
            5'd20:   pkt_byte = "0";
            5'd21:   pkt_byte = "0";
            5'd22:   pkt_byte = "s";
            5'd23:   pkt_byte = r_status ? "0" : digit_char({2'd0, r_job.seq_hund});
            5'd24:   pkt_byte = r_status ? "0" : digit_char(r_job.seq_tens);
            5'd25:   pkt_byte = r_status ? "0" : digit_char(r_job.seq_ones);
            5'd26:   pkt_byte = CHAR_CR;
            default: pkt_byte = msg_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_status <= 1'b0;
            r_idx    <= 5'd0;
            r_out_v  <= 1'b0;
        end else begin
            if (take) begin
                r_busy   <= 1'b1;
                r_status <= 1'b0;
                r_idx    <= 5'd0;
            end else if (emit) begin
                if (last_byte) begin
                    r_idx <= 5'd0;
                    if (run_end) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_status <= 1'b1;
                    end
                end else begin
                    r_idx <= r_idx + 5'd1;
                end
            end
            if (!r_out_v || !i_out_stall) begin
                r_out_v <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job <= i_q_job;
        end
        if (emit) begin
            r_byte <= pkt_byte;
            r_end  <= last_byte;
            r_last <= run_end;
        end
    end

    assign o_out_valid   = r_out_v;
    assign o_data_byte   = r_byte;
    assign o_packet_end  = r_end;
    assign o_last_of_run = r_last;

    a_last_on_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_last) |-> (r_end && r_byte == CHAR_CR))
        else $error("run end flagged away from a packet end");

    a_status_after_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_status) |-> r_job.wrap)
        else $error("status packet without a sequence wrap");

endmodule

/* rtl/sensor_ascii_packet_framer.sv */
// ----------------------------------------------------------------------------
// sensor_ascii_packet_framer
// Frames temperature and humidity readings as 27-byte ASCII packets.
//
// Input channel: one reading per beat (i_in_valid / o_in_stall), action
// selects temperature or humidity. Output channel: one packet byte per beat
// (o_out_valid / i_out_stall) with packet-end and run-end flags.
// Configuration: write i_cfg_we with an index for enable, PAN and unit codes;
// write only while no packet is in flight.
//
// Path: with the queue and byte engine idle, a reading passes the digit
// stages, is written into the job queue, is loaded into the byte engine,
// and its first byte is then presented through the output register.
// Throughput: one byte per cycle unless the receiver stalls; a reading
// yields 27 bytes, or 54 when the sequence wraps and a status packet
// follows. The output register sets this rate; up to four framed readings
// wait in the job queue, so input readings are taken while bytes go out.
// Reset: clears the sequence, registers and queue; the block is disabled and
// readings are taken and dropped until enable is written. A stalled receiver
// holds the current byte; the queue then fills and the input stalls.
// ----------------------------------------------------------------------------
module sensor_ascii_packet_framer
    import spf_pkg::*;
#(
    parameter int Q_DEPTH = QUEUE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_action,
    input  logic [15:0]            i_temp_centi,
    input  logic [15:0]            i_hum_centi,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [7:0]             o_data_byte,
    output logic                   o_packet_end,
    output logic                   o_last_of_run
);

    logic        r_enable;
    logic [15:0] r_pan_code;
    logic [7:0]  r_unit_code;

    logic        q_full;
    logic        q_push;
    t_job        q_push_job;
    logic        q_pop;
    logic        q_valid;
    t_job        q_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_pan_code  <= 16'd0;
            r_unit_code <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENABLE: r_enable    <= i_cfg_data[0];
                CFG_PAN:    r_pan_code  <= i_cfg_data[15:0];
                CFG_UNIT:   r_unit_code <= i_cfg_data[7:0];
                default:    ;
            endcase
        end
    end

    spf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_enable     (r_enable),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_temp_centi (i_temp_centi),
        .i_hum_centi  (i_hum_centi),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_push_job   (q_push_job)
    );

    spf_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_job (q_push_job),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_valid    (q_valid),
        .o_job      (q_job)
    );

    spf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pan_code    (r_pan_code),
        .i_unit_code   (r_unit_code),
        .i_q_valid     (q_valid),
        .i_q_job       (q_job),
        .o_pop         (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_data_byte   (o_data_byte),
        .o_packet_end  (o_packet_end),
        .o_last_of_run (o_last_of_run)
    );

endmodule

/* tb/spf_tb_pkg.sv */
// ----------------------------------------------------------------------------
// spf_tb_pkg
// Codes shared by the framer testbench and its stream checker.
// ----------------------------------------------------------------------------
package spf_tb_pkg;

    // Reading kinds carried on the action field.
    localparam logic ACT_TEMP = 1'b0;
    localparam logic ACT_HUM  = 1'b1;

endpackage

/* tb/spf_stream_checker.sv */
// ----------------------------------------------------------------------------
// spf_stream_checker
// Watches the reading and byte channels of the packet framer. Every reading
// taken while enabled is framed here into the bytes it should produce; every
// byte the framer hands out is compared against the oldest of them.
// ----------------------------------------------------------------------------
module spf_stream_checker
    import spf_pkg::*;
    import spf_tb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic                   i_action,
    input  logic [15:0]            i_temp_centi,
    input  logic [15:0]            i_hum_centi,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_packet_end,
    input  logic                   i_last_of_run,
    output int                     o_fail_count,
    output int                     o_pending
);

    localparam int PKT_BYTES   = 27;
    localparam int MSG_BYTES   = 9;
    localparam int MAX_REPORTS = 40;

    typedef logic [0:MSG_BYTES-1][7:0] t_msg;

    typedef struct packed {
        logic [7:0] data;
        logic       pkt_end;
        logic       run_end;
    } t_beat;

    localparam t_msg STATUS_MSG = "SS361#H1W";

    logic       enable_q;
    logic [15:0] pan_q;
    logic [7:0] unit_q;
    logic [7:0] seq_q;
    t_beat      expected_bytes[$];
    int         fails;

    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        string digits;
        digits = "0123456789ABCDEF";
        return digits[nib];
    endfunction

    function automatic logic [7:0] dec_ascii(input int n);
        return 8'(n + 48);
    endfunction

    function automatic t_msg temp_message(input logic [15:0] raw);
        int   t;
        int   tenths;
        int   mag;
        int   whole;
        t_msg m;
        t = int'($signed(raw));
        // Integer division truncates toward zero, so this rounds half away from zero.
        tenths = (t >= 0) ? (t + 5) / 10 : (t - 5) / 10;
        mag = (tenths < 0) ? -tenths : tenths;
        whole = mag / 10;
        if (whole > int'(WHOLE_MAX)) begin
            whole = int'(WHOLE_MAX);
        end
        m[0] = "T";
        m[1] = "S";
        m[2] = "S";
        m[3] = "A";
        m[4] = (tenths < 0) ? "-" : "+";
        m[5] = dec_ascii(whole / 10);
        m[6] = dec_ascii(whole % 10);
        m[7] = ".";
        m[8] = dec_ascii(mag % 10);
        return m;
    endfunction

    function automatic t_msg humidity_message(input logic [15:0] raw);
        int   tenths;
        int   whole;
        t_msg m;
        tenths = (int'(raw) + 5) / 10;
        whole = tenths / 10;
        if (whole > int'(WHOLE_MAX)) begin
            whole = int'(WHOLE_MAX);
        end
        m[0] = "H";
        m[1] = "S";
        m[2] = "S";
        m[3] = "A";
        m[4] = dec_ascii(whole / 10);
        m[5] = dec_ascii(whole % 10);
        m[6] = ".";
        m[7] = dec_ascii(tenths % 10);
        m[8] = "-";
        return m;
    endfunction

    task automatic report_mismatch(input string line);
        if (fails < MAX_REPORTS) begin
            $display("[%0t] MISMATCH: %s", $time, line);
        end
        fails++;
    endtask

    task automatic push_packet(input t_msg msg, input logic [7:0] seq, input logic ends_run);
        logic [7:0] pkt [0:PKT_BYTES-1];
        t_beat      b;
        int         i;
        pkt[0] = "m";
        pkt[1] = hex_ascii(pan_q[15:12]);
        pkt[2] = hex_ascii(pan_q[11:8]);
        pkt[3] = hex_ascii(pan_q[7:4]);
        pkt[4] = hex_ascii(pan_q[3:0]);
        pkt[5] = hex_ascii(unit_q[7:4]);
        pkt[6] = hex_ascii(unit_q[3:0]);
        pkt[7] = "d";
        for (i = 0; i < MSG_BYTES; i++) begin
            pkt[int'(MSG_FIRST) + i] = msg[i];
        end
        pkt[17] = "r";
        pkt[18] = "-";
        pkt[19] = "0";
        pkt[20] = "0";
        pkt[21] = "0";
        pkt[22] = "s";
        pkt[23] = dec_ascii(int'(seq) / 100);
        pkt[24] = dec_ascii((int'(seq) / 10) % 10);
        pkt[25] = dec_ascii(int'(seq) % 10);
        pkt[26] = CHAR_CR;
        for (i = 0; i < PKT_BYTES; i++) begin
            b.data    = pkt[i];
            b.pkt_end = (i == PKT_BYTES - 1);
            b.run_end = ends_run && (i == PKT_BYTES - 1);
            expected_bytes.push_back(b);
        end
    endtask

    task automatic frame_reading(input logic act, input logic [15:0] t, input logic [15:0] h);
        t_msg       msg;
        logic [7:0] next_seq;
        msg = (act == ACT_HUM) ? humidity_message(h) : temp_message(t);
        next_seq = seq_q + 8'd1;
        push_packet(msg, seq_q, next_seq != 8'd0);
        if (next_seq == 8'd0) begin
            // On wrap a status packet closes the run and numbering resumes at one.
            push_packet(STATUS_MSG, 8'd0, 1'b1);
            next_seq = 8'd1;
        end
        seq_q = next_seq;
    endtask

    always @(posedge i_clk) begin
        t_beat want;
        if (!i_rst_n) begin
            enable_q = 1'b0;
            pan_q    = '0;
            unit_q   = '0;
            seq_q    = '0;
            expected_bytes.delete();
        end else begin
            // Bytes are checked before the reading of this edge is framed, so a
            // stray beat can never pair up with a packet that was just queued.
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("byte %02h with no packet pending", i_data_byte));
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_data_byte !== want.data) begin
                        report_mismatch($sformatf("data_byte got %02h want %02h",
                                                  i_data_byte, want.data));
                    end
                    if (i_packet_end !== want.pkt_end) begin
                        report_mismatch($sformatf("packet_end got %b want %b",
                                                  i_packet_end, want.pkt_end));
                    end
                    if (i_last_of_run !== want.run_end) begin
                        report_mismatch($sformatf("last_of_run got %b want %b",
                                                  i_last_of_run, want.run_end));
                    end
                end
            end
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0 && enable_q) begin
                frame_reading(i_action, i_temp_centi, i_hum_centi);
            end
            if (i_cfg_we === 1'b1) begin
                case (i_cfg_index)
                    CFG_ENABLE: enable_q = i_cfg_data[0];
                    CFG_PAN:    pan_q    = i_cfg_data[15:0];
                    CFG_UNIT:   unit_q   = i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
        o_pending    <= expected_bytes.size();
        o_fail_count <= fails;
    end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the sensor packet framer. Outside full-rate phases
// readings are offered with random gaps while the byte sink stalls at random;
// a stream checker beside the block predicts and compares every packet byte.
// ----------------------------------------------------------------------------
module testbench;
    import spf_pkg::*;
    import spf_tb_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT_CYCLES = 1_000_000;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        MODE_FULL_RATE,
        MODE_SLOW_SINK,
        MODE_SLOW_SOURCE
    } t_idle_mode;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;
    logic                   in_valid    = 1'b0;
    logic                   in_stall;
    logic                   in_action   = ACT_TEMP;
    logic [15:0]            in_temp     = '0;
    logic [15:0]            in_hum      = '0;
    logic                   out_valid;
    logic                   out_stall   = 1'b0;
    logic [7:0]             out_byte;
    logic                   out_pkt_end;
    logic                   out_run_end;

    t_idle_mode idle_mode   = MODE_FULL_RATE;
    logic       pressure_on = 1'b0;
    logic       hold_done   = 1'b0;
    int         hold_left   = 0;
    int         fail_count;
    int         pending;

    always #(HALF_PERIOD) clk = ~clk;

    sensor_ascii_packet_framer u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_action      (in_action),
        .i_temp_centi  (in_temp),
        .i_hum_centi   (in_hum),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_data_byte   (out_byte),
        .o_packet_end  (out_pkt_end),
        .o_last_of_run (out_run_end)
    );

    spf_stream_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_action      (in_action),
        .i_temp_centi  (in_temp),
        .i_hum_centi   (in_hum),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_data_byte   (out_byte),
        .i_packet_end  (out_pkt_end),
        .i_last_of_run (out_run_end),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Byte sink. Once pressure is requested it holds off for a long stretch so
    // the job queue fills and the reading channel has to stall.
    always @(posedge clk) begin
        int idle_pct;
        case (idle_mode)
            MODE_SLOW_SINK:   idle_pct = 88;
            MODE_SLOW_SOURCE: idle_pct = 10;
            default:          idle_pct = 0;
        endcase
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (pressure_on && !hold_done) begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < idle_pct);
        end
    end

    task automatic send_reading(input logic act, input logic [15:0] t, input logic [15:0] h);
        int idle_pct;
        case (idle_mode)
            MODE_SLOW_SINK:   idle_pct = 10;
            MODE_SLOW_SOURCE: idle_pct = 88;
            default:          idle_pct = 0;
        endcase
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_action <= act;
        in_temp   <= t;
        in_hum    <= h;
        @(posedge clk);
        while (in_stall !== 1'b0) begin
            @(posedge clk);
        end
    endtask

    // The unused field of each beat carries random bits.
    task automatic send_temp(input int t);
        send_reading(ACT_TEMP, 16'(t), 16'($urandom));
    endtask

    task automatic send_hum(input int h);
        send_reading(ACT_HUM, 16'($urandom), 16'(h));
    endtask

    task automatic send_random_reading();
        int val;
        case ($urandom_range(0, 3))
            0:       val = int'($urandom_range(0, 65535));
            1:       val = int'($urandom_range(0, 20000)) - 10000;
            // Exact rounding midpoints.
            2:       val = (int'($urandom_range(0, 2000)) - 1000) * 10
                           + (($urandom_range(0, 1) != 0) ? 5 : -5);
            default: val = int'($urandom_range(0, 40)) - 20;
        endcase
        if ($urandom_range(0, 1) != 0) begin
            send_hum(val);
        end else begin
            send_temp(val);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Lets every queued byte drain, then allows for a dropped reading still
    // moving through the digit stages.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Out of reset the block is disabled: readings are taken and dropped.
        repeat (3) send_random_reading();
        wait_idle();
        write_reg(CFG_ENABLE, 16'hFFFE);
        write_reg(CFG_UNUSED, 16'hFFFF);
        repeat (2) send_random_reading();
        wait_idle();

        // Upper data bits must not matter for the narrow registers.
        write_reg(CFG_ENABLE, 16'hFFFF);
        write_reg(CFG_PAN, 16'hFFFF);
        write_reg(CFG_UNIT, 16'hA5FF);

        send_temp(0);
        send_temp(4);
        send_temp(5);
        send_temp(-4);
        send_temp(-5);
        send_temp(-6);
        send_temp(15);
        send_temp(-15);
        send_temp(9994);
        send_temp(9995);
        send_temp(-9995);
        send_temp(32767);
        send_temp(-32768);
        send_temp(-1);
        send_hum(0);
        send_hum(4);
        send_hum(5);
        send_hum(995);
        send_hum(1234);
        send_hum(9994);
        send_hum(9995);
        send_hum(10000);
        send_hum(65535);
        wait_idle();

        idle_mode <= MODE_SLOW_SINK;
        write_reg(CFG_PAN, 16'($urandom));
        write_reg(CFG_UNIT, 16'($urandom));
        repeat (30) send_random_reading();
        wait_idle();

        write_reg(CFG_ENABLE, 16'h0000);
        repeat (4) send_random_reading();
        wait_idle();
        write_reg(CFG_ENABLE, 16'h0001);
        write_reg(CFG_PAN, 16'h0000);
        write_reg(CFG_UNIT, 16'h0000);
        idle_mode <= MODE_SLOW_SOURCE;
        repeat (30) send_random_reading();
        wait_idle();

        // Full-rate phase with one long sink hold-off.
        write_reg(CFG_PAN, 16'($urandom));
        write_reg(CFG_UNIT, 16'($urandom));
        idle_mode   <= MODE_FULL_RATE;
        pressure_on <= 1'b1;
        repeat (28) send_random_reading();
        wait_idle();

        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
